[hw/rtl/balanced_fold_count_search_macros.svh]
// ----------------------------------------------------------------------------
// balanced_fold_count_search assertion macros
// shared concurrent assertion forms for the fold count search block
// ----------------------------------------------------------------------------
`ifndef BALANCED_FOLD_COUNT_SEARCH_MACROS_SVH
`define BALANCED_FOLD_COUNT_SEARCH_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BFCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define BFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bfcs_pkg.sv]
// ----------------------------------------------------------------------------
// bfcs_pkg
// shared widths and constants of the fold count search block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfcs_pkg;

	// width of every count field on the ports
	localparam int FIELD_W = 32;

	// residue threshold after reset
	localparam logic [FIELD_W-1:0] RESIDUE_RESET = 32'd10;

endpackage

[hw/rtl/bfcs_req_if.sv]
// ----------------------------------------------------------------------------
// bfcs_req_if
// request channel: total item count and requested fold count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfcs_req_if;

	logic                        valid;
	logic                        ready;
	logic [bfcs_pkg::FIELD_W-1:0] total_count;
	logic [bfcs_pkg::FIELD_W-1:0] requested_folds;

	modport source (
		output valid,
		output total_count,
		output requested_folds,
		input  ready
	);

	modport sink (
		input  valid,
		input  total_count,
		input  requested_folds,
		output ready
	);

endinterface

[hw/rtl/bfcs_rsp_if.sv]
// ----------------------------------------------------------------------------
// bfcs_rsp_if
// response channel: chosen fold count, segment sizes and found flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfcs_rsp_if;

	logic                        valid;
	logic                        ready;
	logic [bfcs_pkg::FIELD_W-1:0] chosen_folds;
	logic [bfcs_pkg::FIELD_W-1:0] segment_size;
	logic [bfcs_pkg::FIELD_W-1:0] leftover;
	logic [bfcs_pkg::FIELD_W-1:0] last_segment_size;
	logic                        found;

	modport source (
		output valid,
		output chosen_folds,
		output segment_size,
		output leftover,
		output last_segment_size,
		output found,
		input  ready
	);

	modport sink (
		input  valid,
		input  chosen_folds,
		input  segment_size,
		input  leftover,
		input  last_segment_size,
		input  found,
		output ready
	);

endinterface

[hw/rtl/balanced_fold_count_search.sv]
// Each quotient run tried uses the shared divider for two or three divisions, and the answer
// adds at most one final division. One transaction is taken at a time on the single shared
// divider, and the number of runs tried grows with the square root of the total.
// Reset: arst_n clears the sequencer and output valid and sets the residue threshold
// to 10; there is no clearing pass.
// ----------------------------------------------------------------------------
// balanced_fold_count_search
// outward search for a fold count with small remainder, run on one divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "balanced_fold_count_search_macros.svh"

module balanced_fold_count_search #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bfcs_pkg::FIELD_W-1:0] cfg_wdata,
	bfcs_req_if.sink                     req,
	bfcs_rsp_if.source                   rsp
);

	localparam int W  = COUNT_WIDTH;
	localparam int FW = bfcs_pkg::FIELD_W;
	localparam int CW = (W > FW) ? W : FW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_DN_INIT,
		S_DN_CHK,
		S_DN_Q,
		S_DN_LF,
		S_DN_LO,
		S_UP_INIT,
		S_UP_CHK,
		S_UP_Q,
		S_UP_HI,
		S_UP_LF,
		S_DECIDE,
		S_FIN,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [FW-1:0] thr_q;
	logic [W-1:0]  t_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  dmax_q;
	logic [W-1:0]  c_q;
	logic [W-1:0]  q_q;
	logic [W-1:0]  hi_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  dm_q;
	logic [W-1:0]  dp_q;
	logic          hm_q;
	logic          hp_q;
	logic [W-1:0]  ch_q;
	logic          found_q;
	logic [W-1:0]  seg_q;
	logic [W-1:0]  left_q;

	logic          div_start_q;
	logic [W-1:0]  div_a_q;
	logic [W-1:0]  div_b_q;
	logic          div_busy;
	logic          div_done;
	logic [W-1:0]  div_quot;
	logic [W-1:0]  div_rem;

	logic          rsp_valid_q;
	logic [FW-1:0] rsp_chosen_q;
	logic [FW-1:0] rsp_seg_q;
	logic [FW-1:0] rsp_left_q;
	logic [FW-1:0] rsp_last_q;
	logic          rsp_found_q;

	logic [W-1:0]  lim_src;
	logic [W-1:0]  qm1;
	logic [W-1:0]  lim;
	logic [W-1:0]  fit_n;
	logic [W-1:0]  first;
	logic [W-1:0]  first_up;
	logic [W-1:0]  d_dn;
	logic [W-1:0]  d_up;
	logic [W-1:0]  dmax_a;
	logic [W-1:0]  dmax_b;
	logic [W-1:0]  chosen;
	logic          take_dn;
	logic [W-1:0]  last_w;
	logic [CW-1:0] last_x;
	logic [FW-1:0] last_f;
	logic          out_free;
	logic          dn_c_ok;

	// shared divider
	bfcs_div #(
		.W(W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(div_a_q),
		.divisor (div_b_q),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// remainder limit of a quotient run and the dividend for its least fit
	always_comb begin
		lim_src = (state_q == S_DN_Q) ? div_quot : q_q;
		qm1     = lim_src - W'(1);
		lim     = (CW'(thr_q) < CW'(qm1)) ? W'(thr_q) : qm1;
		fit_n   = t_q - lim;
	end

	// least fitting candidate as a ceiling of the divider result
	always_comb begin
		first    = div_quot + W'(div_rem != '0);
		first_up = (first < c_q) ? c_q : first;
		d_dn     = r_q - c_q;
		d_up     = c_q - r_q;
	end

	// offset bound of the search
	always_comb begin
		dmax_a = (t_q > r_q) ? t_q - r_q : '0;
		dmax_b = (r_q != '0) ? r_q - W'(1) : '0;
	end

	// pick the nearer hit, the smaller side on a tie
	always_comb begin
		take_dn = hm_q && (!hp_q || dm_q <= dp_q);
		if (take_dn) begin
			chosen = r_q - dm_q;
		end else if (hp_q) begin
			chosen = r_q + dp_q;
		end else begin
			chosen = r_q;
		end
	end

	// last segment size with saturation
	always_comb begin
		last_w = (seg_q > ('1 - left_q)) ? '1 : seg_q + left_q;
		last_x = CW'(last_w);
		last_f = (last_x > CW'({FW{1'b1}})) ? {FW{1'b1}} : FW'(last_w);
	end

	assign out_free = !rsp_valid_q || rsp.ready;
	assign dn_c_ok  = (c_q != '0) && (c_q <= r_q) && (c_q <= t_q);

	// residue threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bfcs_pkg::RESIDUE_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// search sequencer with divider requests and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			t_q          <= '0;
			r_q          <= '0;
			dmax_q       <= '0;
			c_q          <= '0;
			q_q          <= '0;
			hi_q         <= '0;
			d_q          <= '0;
			dm_q         <= '0;
			dp_q         <= '0;
			hm_q         <= 1'b0;
			hp_q         <= 1'b0;
			ch_q         <= '0;
			found_q      <= 1'b0;
			seg_q        <= '0;
			left_q       <= '0;
			div_start_q  <= 1'b0;
			div_a_q      <= '0;
			div_b_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_chosen_q <= '0;
			rsp_seg_q    <= '0;
			rsp_left_q   <= '0;
			rsp_last_q   <= '0;
			rsp_found_q  <= 1'b0;
		end else begin
			// output transaction leaves unless a new one replaces it
			if (rsp_valid_q && rsp.ready && state_q != S_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						t_q     <= W'(req.total_count);
						r_q     <= W'(req.requested_folds);
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					dmax_q  <= (dmax_a > dmax_b) ? dmax_a : dmax_b;
					hm_q    <= 1'b0;
					hp_q    <= 1'b0;
					state_q <= S_DN_INIT;
				end
				// downward search over quotient runs
				S_DN_INIT: begin
					if (t_q == '0 || r_q == '0) begin
						state_q <= S_UP_INIT;
					end else begin
						c_q     <= (r_q > t_q) ? t_q : r_q;
						state_q <= S_DN_CHK;
					end
				end
				S_DN_CHK: begin
					if (d_dn >= dmax_q) begin
						state_q <= S_UP_INIT;
					end else begin
						d_q         <= d_dn;
						div_a_q     <= t_q;
						div_b_q     <= c_q;
						div_start_q <= 1'b1;
						state_q     <= S_DN_Q;
					end
				end
				S_DN_Q: begin
					if (div_done) begin
						q_q         <= div_quot;
						div_a_q     <= fit_n;
						div_b_q     <= div_quot;
						div_start_q <= 1'b1;
						state_q     <= S_DN_LF;
					end else begin
						div_start_q <= 1'b0;
					end
				end
				S_DN_LF: begin
					if (div_done) begin
						priority if (c_q >= first) begin
							hm_q    <= 1'b1;
							dm_q    <= d_q;
							state_q <= S_UP_INIT;
						end else if (q_q == '1) begin
							state_q <= S_UP_INIT;
						end else begin
							div_a_q     <= t_q;
							div_b_q     <= q_q + W'(1);
							div_start_q <= 1'b1;
							state_q     <= S_DN_LO;
						end
					end else begin
						div_start_q <= 1'b0;
					end
				end
				S_DN_LO: begin
					if (div_done) begin
						if (div_quot == '0) begin
							state_q <= S_UP_INIT;
						end else begin
							c_q     <= div_quot;
							state_q <= S_DN_CHK;
						end
					end else begin
						div_start_q <= 1'b0;
					end
				end
				// upward search over quotient runs
				S_UP_INIT: begin
					c_q     <= (r_q == '0) ? W'(1) : r_q;
					state_q <= S_UP_CHK;
				end
				S_UP_CHK: begin
					if (c_q > t_q || d_up >= dmax_q) begin
						state_q <= S_DECIDE;
					end else begin
						div_a_q     <= t_q;
						div_b_q     <= c_q;
						div_start_q <= 1'b1;
						state_q     <= S_UP_Q;
					end
				end
				S_UP_Q: begin
					if (div_done) begin
						q_q         <= div_quot;
						div_a_q     <= t_q;
						div_b_q     <= div_quot;
						div_start_q <= 1'b1;
						state_q     <= S_UP_HI;
					end else begin
						div_start_q <= 1'b0;
					end
				end
				S_UP_HI: begin
					if (div_done) begin
						hi_q        <= div_quot;
						div_a_q     <= fit_n;
						div_b_q     <= q_q;
						div_start_q <= 1'b1;
						state_q     <= S_UP_LF;
					end else begin
						div_start_q <= 1'b0;
					end
				end
				S_UP_LF: begin
					if (div_done) begin
						priority if (first_up <= hi_q) begin
							if ((first_up - r_q) < dmax_q) begin
								hp_q <= 1'b1;
								dp_q <= first_up - r_q;
							end
							state_q <= S_DECIDE;
						end else if (hi_q == '1) begin
							state_q <= S_DECIDE;
						end else begin
							c_q     <= hi_q + W'(1);
							state_q <= S_UP_CHK;
						end
					end else begin
						div_start_q <= 1'b0;
					end
				end
				// final split for the chosen count
				S_DECIDE: begin
					ch_q    <= chosen;
					found_q <= hm_q || hp_q;
					if (chosen == '0) begin
						seg_q   <= '0;
						left_q  <= t_q;
						state_q <= S_EMIT;
					end else begin
						div_a_q     <= t_q;
						div_b_q     <= chosen;
						div_start_q <= 1'b1;
						state_q     <= S_FIN;
					end
				end
				S_FIN: begin
					if (div_done) begin
						seg_q   <= div_quot;
						left_q  <= div_rem;
						state_q <= S_EMIT;
					end else begin
						div_start_q <= 1'b0;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_chosen_q <= FW'(ch_q);
						rsp_seg_q    <= FW'(seg_q);
						rsp_left_q   <= FW'(left_q);
						rsp_last_q   <= last_f;
						rsp_found_q  <= found_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready             = (state_q == S_IDLE);
	assign rsp.valid             = rsp_valid_q;
	assign rsp.chosen_folds      = rsp_chosen_q;
	assign rsp.segment_size      = rsp_seg_q;
	assign rsp.leftover          = rsp_left_q;
	assign rsp.last_segment_size = rsp_last_q;
	assign rsp.found             = rsp_found_q;

	// divider is only started when free and then runs
	`BFCS_ASSERT_IMPL(a_div_idle, clk, arst_n, div_start_q, !div_busy, "divider started while busy")
	`BFCS_ASSERT_NEXT(a_div_runs, clk, arst_n, div_start_q, div_busy, "divider did not start")
	// downward candidate stays within one and the request and total
	`BFCS_ASSERT_IMPL(a_dn_range, clk, arst_n, state_q == S_DN_CHK, dn_c_ok, "downward candidate out of range")
	// upward candidate is never zero
	`BFCS_ASSERT_IMPL(a_up_nonzero, clk, arst_n, state_q == S_UP_CHK, c_q != '0, "upward candidate is zero")
	// no new transaction while a search is running
	`BFCS_ASSERT_IMPL(a_busy_hold, clk, arst_n, state_q != S_IDLE, !req.ready, "request taken during search")

endmodule

[hw/rtl/bfcs_div.sv]
// ----------------------------------------------------------------------------
// bfcs_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfcs_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CNT_W = $clog2(W);

	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     dvs_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       rem_sh;
	logic [W:0]       rem_sub;
	logic             fits;

	// shift in the next dividend bit and trial subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = rem_sh >= {1'b0, dvs_q};
	end

	// iteration control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
				rem_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[W-2:0], fits};
				rem_q <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
